[rtl/tbd_pkg.sv]
// ----------------------------------------------------------------------------
// tbd_pkg
// Shared types, codes and helper functions for the texture block decompressor.
// ----------------------------------------------------------------------------
package tbd_pkg;

    localparam logic [2:0] FMT_BC1 = 3'd0;
    localparam logic [2:0] FMT_BC3 = 3'd1;
    localparam logic [2:0] FMT_BC4 = 3'd2;
    localparam logic [2:0] FMT_BC5 = 3'd3;
    localparam logic [2:0] FMT_BC7 = 3'd4;
    localparam logic [2:0] FMT_EAC = 3'd5;

    // front-end to back-end queue entry
    typedef struct packed {
        logic [2:0]  fmt;
        logic [63:0] lo;
        logic [63:0] hi;
    } t_job;

    // divide by 3 (10-bit input) or by 5 or 7 (11-bit input) via reciprocal multiply; the quotient is 8 bits
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [21:0] p;
        p = {12'd0, v} * 22'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] v);
        logic [24:0] p;
        p = {14'd0, v} * 25'd3277;
        return p[21:14];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] v);
        logic [25:0] p;
        p = {15'd0, v} * 26'd2341;
        return p[21:14];
    endfunction

    function automatic logic [6:0] bc7_weight(input logic [3:0] i);
        logic [6:0] w;
        case (i)
            4'd0:  w = 7'd0;   4'd1:  w = 7'd4;   4'd2:  w = 7'd9;   4'd3:  w = 7'd13;
            4'd4:  w = 7'd17;  4'd5:  w = 7'd21;  4'd6:  w = 7'd26;  4'd7:  w = 7'd30;
            4'd8:  w = 7'd34;  4'd9:  w = 7'd38;  4'd10: w = 7'd43;  4'd11: w = 7'd47;
            4'd12: w = 7'd51;  4'd13: w = 7'd55;  4'd14: w = 7'd60;  default: w = 7'd64;
        endcase
        return w;
    endfunction

    function automatic logic signed [4:0] eac_mod(input logic [3:0] t, input logic [2:0] s);
        logic [39:0] row;
        logic [4:0]  m;
        case (t)
            4'd0:  row = {-5'sd3, -5'sd6, -5'sd9, -5'sd15, 5'sd2, 5'sd5, 5'sd8, 5'sd14};
            4'd1:  row = {-5'sd3, -5'sd7, -5'sd10, -5'sd13, 5'sd2, 5'sd6, 5'sd9, 5'sd12};
            4'd2:  row = {-5'sd2, -5'sd5, -5'sd8, -5'sd13, 5'sd1, 5'sd4, 5'sd7, 5'sd12};
            4'd3:  row = {-5'sd2, -5'sd4, -5'sd6, -5'sd13, 5'sd1, 5'sd3, 5'sd5, 5'sd12};
            4'd4:  row = {-5'sd3, -5'sd6, -5'sd8, -5'sd12, 5'sd2, 5'sd5, 5'sd7, 5'sd11};
            4'd5:  row = {-5'sd3, -5'sd7, -5'sd9, -5'sd11, 5'sd2, 5'sd6, 5'sd8, 5'sd10};
            4'd6:  row = {-5'sd4, -5'sd7, -5'sd8, -5'sd11, 5'sd3, 5'sd6, 5'sd7, 5'sd10};
            4'd7:  row = {-5'sd3, -5'sd5, -5'sd8, -5'sd11, 5'sd2, 5'sd4, 5'sd7, 5'sd10};
            4'd8:  row = {-5'sd2, -5'sd6, -5'sd8, -5'sd10, 5'sd1, 5'sd5, 5'sd7, 5'sd9};
            4'd9:  row = {-5'sd2, -5'sd5, -5'sd8, -5'sd10, 5'sd1, 5'sd4, 5'sd7, 5'sd9};
            4'd10: row = {-5'sd2, -5'sd4, -5'sd8, -5'sd10, 5'sd1, 5'sd3, 5'sd7, 5'sd9};
            4'd11: row = {-5'sd2, -5'sd5, -5'sd7, -5'sd10, 5'sd1, 5'sd4, 5'sd6, 5'sd9};
            4'd12: row = {-5'sd3, -5'sd4, -5'sd7, -5'sd10, 5'sd2, 5'sd3, 5'sd6, 5'sd9};
            4'd13: row = {-5'sd1, -5'sd2, -5'sd3, -5'sd10, 5'sd0, 5'sd1, 5'sd2, 5'sd9};
            4'd14: row = {-5'sd4, -5'sd6, -5'sd8, -5'sd9, 5'sd3, 5'sd5, 5'sd7, 5'sd8};
            default: row = {-5'sd3, -5'sd5, -5'sd7, -5'sd9, 5'sd2, 5'sd4, 5'sd6, 5'sd8};
        endcase
        m = row[39 - 5*s -: 5];
        return $signed(m);
    endfunction

endpackage

[rtl/tbd_front.sv]
// ----------------------------------------------------------------------------
// tbd_front
// Accepts blocks, tags them with the current format and queues them (2 deep).
// ----------------------------------------------------------------------------
module tbd_front import tbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_fmt,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_hi,
    output logic        o_job_valid,
    input  logic        i_job_take,
    output t_job        o_job
);
    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_full      = r_cnt[1];
    assign o_job_valid = r_cnt != 2'd0;
    assign o_job       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_job_take && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
        if (w_wr) r_q[r_wp] <= '{fmt: i_fmt, lo: i_lo, hi: i_hi};
    end
endmodule

[rtl/tbd_back.sv]
// ----------------------------------------------------------------------------
// tbd_back
// Builds palettes for one block (registered), then emits one row per cycle
// into a two-entry output queue while that queue has room.
// ----------------------------------------------------------------------------
module tbd_back import tbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_take,
    input  t_job        i_job,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_pixel_0,
    output logic [31:0] o_pixel_1,
    output logic [31:0] o_pixel_2,
    output logic [31:0] o_pixel_3,
    output logic [1:0]  o_row_number,
    output logic        o_last_row,
    output logic        o_block_ok
);
    // stage 1: palettes
    logic [31:0] r_cpal [4];    // BC1 colour palette
    logic [7:0]  r_apal [8];    // BC4 palette from lo
    logic [7:0]  r_bpal [8];    // BC4 palette from hi
    logic [7:0]  r_e0 [4];
    logic [7:0]  r_e1 [4];
    logic [63:0] r_lo, r_hi;
    logic [2:0]  r_fmt;
    logic        r_ok, r_busy;
    logic [1:0]  r_row;

    // output queue
    typedef struct packed {
        logic [127:0] px;
        logic [1:0]   row;
        logic         ok;
    } t_res;
    t_res       r_oq [2];
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;
    logic       w_emit, w_pop;

    // combinational palette build from the incoming job
    logic [63:0] w_ch;
    logic [31:0] w_cpal [4];
    logic [7:0]  w_apal [8];
    logic [7:0]  w_bpal [8];
    logic        w_three;

    function automatic void bc4_pal(input logic [15:0] e, output logic [7:0] p [8]);
        logic [7:0] l, h;
        l = e[7:0];
        h = e[15:8];
        p[0] = l;
        p[1] = h;
        if (l > h) begin
            for (int i = 1; i < 7; i++)
                p[i+1] = div7(11'(l * (7 - i)) + 11'(h * i));
        end else begin
            for (int i = 1; i < 5; i++)
                p[i+1] = div5(11'(l * (5 - i)) + 11'(h * i));
            p[6] = 8'd0;
            p[7] = 8'd255;
        end
    endfunction

    always_comb begin
        logic [7:0] r0, g0, b0, r1, g1, b1;
        w_ch = (i_job.fmt == FMT_BC3) ? i_job.hi : i_job.lo;
        r0 = {w_ch[15:11], w_ch[15:13]};
        g0 = {w_ch[10:5], w_ch[10:9]};
        b0 = {w_ch[4:0], w_ch[4:2]};
        r1 = {w_ch[31:27], w_ch[31:29]};
        g1 = {w_ch[26:21], w_ch[26:25]};
        b1 = {w_ch[20:16], w_ch[20:18]};
        w_three = !(w_ch[15:0] > w_ch[31:16]);
        w_cpal[0] = {8'd255, b0, g0, r0};
        w_cpal[1] = {8'd255, b1, g1, r1};
        if (!w_three) begin
            w_cpal[2] = {8'd255, div3({1'b0, b0, 1'b0} + 10'(b1)),
                         div3({1'b0, g0, 1'b0} + 10'(g1)), div3({1'b0, r0, 1'b0} + 10'(r1))};
            w_cpal[3] = {8'd255, div3({1'b0, b1, 1'b0} + 10'(b0)),
                         div3({1'b0, g1, 1'b0} + 10'(g0)), div3({1'b0, r1, 1'b0} + 10'(r0))};
        end else begin
            w_cpal[2] = {8'd255, 8'((9'(b0) + 9'(b1)) >> 1), 8'((9'(g0) + 9'(g1)) >> 1),
                         8'((9'(r0) + 9'(r1)) >> 1)};
            w_cpal[3] = 32'd0;
        end
        bc4_pal(i_job.lo[15:0], w_apal);
        bc4_pal(i_job.hi[15:0], w_bpal);
    end

    assign w_emit     = r_busy && (r_ocnt != 2'd2 || w_pop);
    assign o_job_take = i_job_valid && (!r_busy || (w_emit && r_row == 2'd3));
    assign o_empty    = r_ocnt == 2'd0;
    assign w_pop      = i_pop && !o_empty;

    // row pixel generation
    logic [127:0] w_px;
    always_comb begin
        for (int x = 0; x < 4; x++) begin
            logic [3:0]  idx;
            logic [31:0] c;
            logic [2:0]  as, bs, es;
            logic [3:0]  ws;
            logic [6:0]  w;
            logic signed [10:0] a;
            logic [47:0] esel;
            idx = {r_row, 2'(x)};
            as = r_lo[16 + 3*idx +: 3];
            bs = r_hi[16 + 3*idx +: 3];
            c = 32'd0;
            a = '0;
            esel = {r_lo[23:16], r_lo[31:24], r_lo[39:32], r_lo[47:40],
                    r_lo[55:48], r_lo[63:56]};
            es = esel[45 - 3*(4*x + r_row) +: 3];
            ws = (idx == 4'd0) ? {1'b0, r_hi[3:1]} : r_hi[4*idx +: 4];
            w = bc7_weight(ws);
            case (r_fmt)
                FMT_BC1: c = r_cpal[r_lo[32 + 2*idx +: 2]];
                FMT_BC3: c = {r_apal[as], r_cpal[r_hi[32 + 2*idx +: 2]][23:0]};
                FMT_BC4: c = {8'd255, 16'd0, r_apal[as]};
                FMT_BC5: c = {8'd255, 8'd0, r_bpal[bs], r_apal[as]};
                FMT_BC7: begin
                    for (int k = 0; k < 4; k++)
                        c[8*k +: 8] = 8'((15'(r_e0[k]) * 15'(7'd64 - w)
                                         + 15'(r_e1[k]) * 15'(w) + 15'd32) >> 6);
                    if (!r_ok) c = 32'd0;
                end
                FMT_EAC: begin
                    a = $signed({3'b0, r_lo[7:0]})
                        + eac_mod(r_lo[11:8], es) * $signed({1'b0, r_lo[15:12]});
                    c = {(a < 0) ? 8'd0 : (a > 255) ? 8'd255 : a[7:0], 24'd0};
                end
                default: c = 32'd0;
            endcase
            w_px[32*x +: 32] = c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= 2'd0;
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_emit) r_row <= r_row + 2'd1;
            if (o_job_take) r_busy <= 1'b1;
            else if (w_emit && r_row == 2'd3) r_busy <= 1'b0;
            if (w_emit) r_owp <= !r_owp;
            if (w_pop) r_orp <= !r_orp;
            r_ocnt <= r_ocnt + {1'b0, w_emit} - {1'b0, w_pop};
        end
        if (o_job_take) begin
            r_fmt <= i_job.fmt;
            r_lo  <= i_job.lo;
            r_hi  <= i_job.hi;
            r_cpal <= w_cpal;
            r_apal <= w_apal;
            r_bpal <= w_bpal;
            for (int k = 0; k < 4; k++) begin
                r_e0[k] <= {i_job.lo[7 + 14*k +: 7], i_job.lo[63]};
                r_e1[k] <= {i_job.lo[14 + 14*k +: 7], i_job.hi[0]};
            end
            case (i_job.fmt)
                FMT_BC1, FMT_BC4, FMT_BC5, FMT_EAC: r_ok <= 1'b1;
                FMT_BC3: r_ok <= !w_three;
                FMT_BC7: r_ok <= i_job.lo[6:0] == 7'h40;
                default: r_ok <= 1'b0;
            endcase
        end
        if (w_emit) r_oq[r_owp] <= '{px: w_px, row: r_row, ok: r_ok};
    end

    assign o_pixel_0    = r_oq[r_orp].px[31:0];
    assign o_pixel_1    = r_oq[r_orp].px[63:32];
    assign o_pixel_2    = r_oq[r_orp].px[95:64];
    assign o_pixel_3    = r_oq[r_orp].px[127:96];
    assign o_row_number = r_oq[r_orp].row;
    assign o_last_row   = r_oq[r_orp].row == 2'd3;
    assign o_block_ok   = r_oq[r_orp].ok;
endmodule

[rtl/texture_block_decompressor.sv]
// ----------------------------------------------------------------------------
// texture_block_decompressor
// Decodes 4x4 BCn / EAC alpha blocks into rows of RGBA8 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive block halves with push while full is low; a transfer
//   takes place on each such edge. A two-entry queue holds accepted blocks.
//   Format register: write enable and 3-bit data, change only when idle.
//   Result queue: a row is on the outputs while empty is low; pop transfers
//   it. Rows come out 0..3, last_row marks row 3.
//   A block goes through the input queue, the palette registers and the
//   result queue. The single row generator emits one row per cycle while
//   the result queue has room and takes a new block with the last row.
//   Reset empties both queues and sets the format to BC1.
//   When pop is held low the two-entry result queue fills, row generation
//   pauses, then the input queue fills and full rises.
// ----------------------------------------------------------------------------
module texture_block_decompressor import tbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_pixel_0,
    output logic [31:0] o_pixel_1,
    output logic [31:0] o_pixel_2,
    output logic [31:0] o_pixel_3,
    output logic [1:0]  o_row_number,
    output logic        o_last_row,
    output logic        o_block_ok
);
    logic [2:0] r_fmt;
    logic       w_jv, w_jt;
    t_job       w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fmt <= FMT_BC1;
        else if (i_cfg_we) r_fmt <= i_cfg_data;
    end

    tbd_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_fmt(r_fmt),
        .i_lo(i_block_low), .i_hi(i_block_high),
        .o_job_valid(w_jv), .i_job_take(w_jt), .o_job(w_job)
    );

    tbd_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_jv), .o_job_take(w_jt), .i_job(w_job),
        .o_empty(empty), .i_pop(pop), .o_pixel_0, .o_pixel_1, .o_pixel_2,
        .o_pixel_3, .o_row_number, .o_last_row, .o_block_ok
    );
endmodule

[rtl/tbd_checker.sv]
// ----------------------------------------------------------------------------
// tbd_checker
// Port-level checks on the result ordering of the decompressor.
// ----------------------------------------------------------------------------
module tbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_row_number,
    input logic       o_last_row
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_row == (o_row_number == 2'd3)))
        else $error("last_row mismatch");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_row) ##1 !empty |->
            o_row_number == $past(o_row_number) + 2'd1)
        else $error("row order broken");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_row_number)))
        else $error("stalled row changed");
endmodule

bind texture_block_decompressor tbd_checker u_chk (
    .i_clk, .i_rst_n, .empty, .pop, .o_row_number, .o_last_row
);

[tb/sv/texture_block_decompressor_test.sv]
// ----------------------------------------------------------------------------
// texture_block_decompressor_test
// Drives compressed 4x4 blocks through every format (BC1, BC3, BC4, BC5,
// BC7 mode 6, EAC alpha and the unused codes), predicts the four pixel rows
// of each block and checks every row transfer field by field.
// ----------------------------------------------------------------------------
module texture_block_decompressor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tbd_pkg::*;

    typedef struct {
        logic [31:0] px[4];
        logic [1:0]  row;
        logic        last;
        logic        ok;
    } t_row;

    class row_scoreboard;
        t_row        pending_rows[$];
        logic [2:0]  fmt;
        int          errors;
        int          rows_checked;

        function new();
            fmt = FMT_BC1;
            errors = 0;
            rows_checked = 0;
        endfunction

        function logic [31:0] pack(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [7:0] a);
            return {a, b, g, r};
        endfunction

        function void rgb565(logic [15:0] c, output logic [7:0] r, output logic [7:0] g,
                             output logic [7:0] b);
            r = {c[15:11], c[15:13]};
            g = {c[10:5], c[10:9]};
            b = {c[4:0], c[4:2]};
        endfunction

        function bit colour_block(logic [63:0] h, output logic [31:0] px[16]);
            logic [7:0]  r0, g0, b0, r1, g1, b1;
            logic [31:0] pal[4];
            bit          three;
            rgb565(h[15:0], r0, g0, b0);
            rgb565(h[31:16], r1, g1, b1);
            pal[0] = pack(r0, g0, b0, 8'hff);
            pal[1] = pack(r1, g1, b1, 8'hff);
            three = !(h[15:0] > h[31:16]);
            if (!three) begin
                pal[2] = pack(8'((2*r0 + r1) / 3), 8'((2*g0 + g1) / 3),
                              8'((2*b0 + b1) / 3), 8'hff);
                pal[3] = pack(8'((2*r1 + r0) / 3), 8'((2*g1 + g0) / 3),
                              8'((2*b1 + b0) / 3), 8'hff);
            end else begin
                pal[2] = pack(8'((r0 + r1) / 2), 8'((g0 + g1) / 2), 8'((b0 + b1) / 2),
                              8'hff);
                pal[3] = 32'h0;
            end
            for (int i = 0; i < 16; i++) px[i] = pal[h[32 + 2*i +: 2]];
            return three;
        endfunction

        function void channel_block(logic [63:0] h, output logic [7:0] v[16]);
            int lo, hi, pal[8];
            lo = int'(h[7:0]);
            hi = int'(h[15:8]);
            pal[0] = lo;
            pal[1] = hi;
            if (lo > hi) begin
                for (int i = 1; i < 7; i++) pal[i + 1] = (lo * (7 - i) + hi * i) / 7;
            end else begin
                for (int i = 1; i < 5; i++) pal[i + 1] = (lo * (5 - i) + hi * i) / 5;
                pal[6] = 0;
                pal[7] = 255;
            end
            for (int i = 0; i < 16; i++) v[i] = 8'(pal[h[16 + 3*i +: 3]]);
        endfunction

        function bit mode6_block(logic [63:0] lo, logic [63:0] hi,
                                 output logic [31:0] px[16]);
            int          wt[16] = '{0, 4, 9, 13, 17, 21, 26, 30, 34, 38, 43, 47, 51, 55, 60, 64};
            int          e0[4], e1[4], ch[4];
            logic [31:0] pal[16];
            if (lo[6:0] != 7'h40) return 0;
            for (int c = 0; c < 4; c++) begin
                e0[c] = int'({lo[7 + 14*c +: 7], lo[63]});
                e1[c] = int'({lo[14 + 14*c +: 7], hi[0]});
            end
            for (int i = 0; i < 16; i++) begin
                for (int c = 0; c < 4; c++)
                    ch[c] = (e0[c] * (64 - wt[i]) + e1[c] * wt[i] + 32) >> 6;
                pal[i] = pack(8'(ch[0]), 8'(ch[1]), 8'(ch[2]), 8'(ch[3]));
            end
            px[0] = pal[hi[3:1]];
            for (int i = 1; i < 16; i++) px[i] = pal[hi[4*i +: 4]];
            return 1;
        endfunction

        function void eac_alpha(logic [63:0] h, output logic [7:0] v[16]);
            int mods[16][8] = '{
                '{-3, -6, -9, -15, 2, 5, 8, 14}, '{-3, -7, -10, -13, 2, 6, 9, 12},
                '{-2, -5, -8, -13, 1, 4, 7, 12}, '{-2, -4, -6, -13, 1, 3, 5, 12},
                '{-3, -6, -8, -12, 2, 5, 7, 11}, '{-3, -7, -9, -11, 2, 6, 8, 10},
                '{-4, -7, -8, -11, 3, 6, 7, 10}, '{-3, -5, -8, -11, 2, 4, 7, 10},
                '{-2, -6, -8, -10, 1, 5, 7, 9},  '{-2, -5, -8, -10, 1, 4, 7, 9},
                '{-2, -4, -8, -10, 1, 3, 7, 9},  '{-2, -5, -7, -10, 1, 4, 6, 9},
                '{-3, -4, -7, -10, 2, 3, 6, 9},  '{-1, -2, -3, -10, 0, 1, 2, 9},
                '{-4, -6, -8, -9, 3, 5, 7, 8},   '{-3, -5, -7, -9, 2, 4, 6, 8}};
            logic [47:0] sel;
            int          a;
            sel = {h[23:16], h[31:24], h[39:32], h[47:40], h[55:48], h[63:56]};
            for (int y = 0; y < 4; y++)
                for (int x = 0; x < 4; x++) begin
                    a = int'(h[7:0]) + mods[h[11:8]][sel[45 - (y + 4*x)*3 +: 3]]
                        * int'(h[15:12]);
                    if (a < 0) a = 0;
                    if (a > 255) a = 255;
                    v[4*y + x] = 8'(a);
                end
        endfunction

        function void note_block(logic [63:0] lo, logic [63:0] hi);
            logic [31:0] px[16];
            logic [7:0]  va[16], vb[16];
            logic        ok;
            t_row        r;
            ok = 1'b1;
            case (fmt)
                FMT_BC1: void'(colour_block(lo, px));
                FMT_BC3: begin
                    if (colour_block(hi, px)) ok = 1'b0;
                    channel_block(lo, va);
                    for (int i = 0; i < 16; i++) px[i][31:24] = va[i];
                end
                FMT_BC4: begin
                    channel_block(lo, va);
                    for (int i = 0; i < 16; i++) px[i] = pack(va[i], 8'd0, 8'd0, 8'hff);
                end
                FMT_BC5: begin
                    channel_block(lo, va);
                    channel_block(hi, vb);
                    for (int i = 0; i < 16; i++) px[i] = pack(va[i], vb[i], 8'd0, 8'hff);
                end
                FMT_BC7: begin
                    if (!mode6_block(lo, hi, px)) begin
                        ok = 1'b0;
                        for (int i = 0; i < 16; i++) px[i] = '0;
                    end
                end
                FMT_EAC: begin
                    eac_alpha(lo, va);
                    for (int i = 0; i < 16; i++) px[i] = pack(8'd0, 8'd0, 8'd0, va[i]);
                end
                default: begin
                    ok = 1'b0;
                    for (int i = 0; i < 16; i++) px[i] = '0;
                end
            endcase
            for (int y = 0; y < 4; y++) begin
                for (int i = 0; i < 4; i++) r.px[i] = px[4*y + i];
                r.row = 2'(y);
                r.last = (y == 3);
                r.ok = ok;
                pending_rows = {pending_rows, r};
            end
        endfunction

        function void check_row(t_row got);
            t_row want;
            rows_checked++;
            if (pending_rows.size() == 0) begin
                $error("row transfer with none expected");
                errors++;
                return;
            end
            want = pending_rows.pop_front();
            for (int i = 0; i < 4; i++)
                if (got.px[i] !== want.px[i]) begin
                    $error("pixel_%0d: expected %h, got %h", i, want.px[i], got.px[i]);
                    errors++;
                end
            if (got.row !== want.row) begin
                $error("row_number: expected %0d, got %0d", want.row, got.row);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_row: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
            if (got.ok !== want.ok) begin
                $error("block_ok: expected %0d, got %0d", want.ok, got.ok);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_data = '0;
    logic        push = 0;
    logic        full;
    logic [63:0] block_low = '0;
    logic [63:0] block_high = '0;
    logic        empty;
    logic        pop = 0;
    logic [31:0] pixel_0, pixel_1, pixel_2, pixel_3;
    logic [1:0]  row_number;
    logic        last_row, block_ok;

    row_scoreboard sb = new();
    int            cycles = 0;
    int            blocks_sent = 0;
    bit            hold_pop = 0;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    texture_block_decompressor u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .push(push), .full(full), .i_block_low(block_low), .i_block_high(block_high),
        .empty(empty), .pop(pop), .o_pixel_0(pixel_0), .o_pixel_1(pixel_1),
        .o_pixel_2(pixel_2), .o_pixel_3(pixel_3), .o_row_number(row_number),
        .o_last_row(last_row), .o_block_ok(block_ok)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stalls, with hold_pop forcing a long one
    initial begin
        int   wait_cycles;
        t_row got;
        @(posedge rst_n);
        forever begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            @(negedge clk);
            pop = 0;
            repeat (wait_cycles) @(negedge clk);
            while (hold_pop) @(negedge clk);
            pop = 1;
            do @(posedge clk); while (empty);
            got.px[0] = pixel_0;
            got.px[1] = pixel_1;
            got.px[2] = pixel_2;
            got.px[3] = pixel_3;
            got.row = row_number;
            got.last = last_row;
            got.ok = block_ok;
            sb.check_row(got);
        end
    end

    task automatic send_block(logic [63:0] lo, logic [63:0] hi, int gap);
        @(negedge clk);
        push = 0;
        repeat (gap) @(negedge clk);
        block_low = lo;
        block_high = hi;
        push = 1;
        do @(posedge clk); while (full);
        sb.note_block(lo, hi);
        blocks_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        push = 0;
        while (sb.pending_rows.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_format(logic [2:0] f);
        drain();
        cfg_data = f;
        cfg_we = 1;
        @(negedge clk);
        cfg_we = 0;
        sb.fmt = f;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly well-formed blocks for the current format, some noise
    function automatic logic [63:0] shaped_low(logic [2:0] f);
        logic [63:0] v;
        v = rand64();
        if (f == FMT_BC7 && $urandom_range(0, 4) != 0) v[6:0] = 7'h40;
        return v;
    endfunction

    initial begin
        int n_rand;
        logic [2:0] f;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset format is BC1: four- and three-colour modes, extremes
        send_block('0, '0, 0);
        send_block('1, '1, 0);
        send_block(64'hE4E4_E4E4_0000_FFFF, '0, 0);
        send_block(64'h1B1B_1B1B_FFFF_0000, '0, 1);
        set_format(FMT_BC3);
        send_block(64'h0123_4567_89AB_10F0, 64'hE4E4_E4E4_0000_F800, 0);
        send_block(64'hFEDC_BA98_7654_F010, 64'hFFFF_FFFF_F800_0000, 0);
        set_format(FMT_BC4);
        send_block(64'hFAC6_88FA_C688_00FF, '0, 0);
        send_block(64'hFAC6_88FA_C688_FF00, '0, 0);
        set_format(FMT_BC5);
        send_block(64'h0539_77FF_FFFF_20C0, 64'hFFFF_FFFF_FFFF_C020, 0);
        set_format(FMT_BC7);
        send_block(64'hFFFF_FFFF_FFFF_FFC0, '1, 0);
        send_block(64'h8000_0000_0000_0040, 64'hFEDC_BA98_7654_3211, 0);
        send_block(64'h0000_0000_0000_0041, '1, 0);
        set_format(FMT_EAC);
        send_block(64'hFFFF_FFFF_FFFF_F0FF, '0, 0);
        send_block(64'h0000_0000_0000_F000, '0, 0);
        send_block(64'h0529_4A52_94A5_D37F, '1, 0);
        set_format(3'd6);
        send_block(rand64(), rand64(), 0);
        set_format(3'd7);
        send_block(rand64(), rand64(), 0);

        // fill the queues up: hold pop off for a long stretch
        set_format(FMT_BC1);
        fork
            begin
                hold_pop = 1;
                repeat (60) @(negedge clk);
                hold_pop = 0;
            end
            for (int i = 0; i < 6; i++) send_block(rand64(), rand64(), 0);
        join

        for (int ph = 0; ph < 8; ph++) begin
            f = (ph < 6) ? 3'(ph) : 3'($urandom_range(0, 7));
            set_format(f);
            n_rand = 32 + $urandom_range(0, 4);
            for (int i = 0; i < n_rand; i++)
                send_block(shaped_low(f), rand64(),
                           (ph % 3 == 0) ? 0 : $urandom_range(0, 15));
        end

        drain();
        repeat (20) @(negedge clk);
        $display("tb: %0d blocks in all formats, %0d rows checked",
                 blocks_sent, sb.rows_checked);
        if (sb.errors == 0 && sb.pending_rows.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
